// File: sv/drc_pkg.sv
// Package for the duplicate request cache: constants, action codes and types.
// No dependencies.
package drc_pkg;

  localparam int unsigned CacheEntriesDefault = 64;
  localparam int unsigned DefinedProcs = 18;

  localparam logic [2:0] ActDrop        = 3'd0;
  localparam logic [2:0] ActReplyStatus = 3'd1;
  localparam logic [2:0] ActReplyBuffer = 3'd2;
  localparam logic [2:0] ActDoIt        = 3'd3;
  localparam logic [2:0] ActUpdated     = 3'd4;
  localparam logic [2:0] ActNoMatch     = 3'd5;

  localparam logic [1:0] CfgDelay   = 2'd0;
  localparam logic [1:0] CfgNonIdem = 2'd1;
  localparam logic [1:0] CfgStatus  = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [31:0] xid;
    logic [4:0]  proc;
    logic [31:0] client_addr;
    logic [31:0] now_seconds;
    logic        reply_valid;
    logic [31:0] reply_status;
  } req_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] cached_status;
    logic [5:0]  entry_index;
    logic        evicted_buffer;
  } rsp_t;

endpackage

// File: sv/drc_if.sv
// Valid/ready channel carrying one beat of a payload type.
// Depends on drc_pkg for the payload types.
interface drc_if #(parameter type payload_t = drc_pkg::req_t) (input logic clk_i);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/duplicate_request_cache.sv
// Top level of the duplicate request cache with a scan sequencer.
// Depends on drc_pkg and drc_if.
//
// Usage: requests arrive as beats on req (kind 0 lookup, kind 1 update);
// each gives exactly one beat on rsp. Configuration is written through
// cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// Each item runs a scan over all entries, one entry per cycle through a
// single key compare, tracking the match and the least recent entry. A
// lookup then runs a second pass, one entry per cycle, to age the ranks
// above the used entry. The apply state then applies the result, and the
// output state holds it on rsp. Only one item is in work at a time; a new
// beat is taken only once the result has been accepted.
// Reset empties the cache, sets ranks to index order and loads the
// register defaults. If the receiver stalls, the result stays held and
// no new item is taken.
module duplicate_request_cache #(
  parameter int unsigned CACHE_ENTRIES = drc_pkg::CacheEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [17:0] cfg_data_i,
  drc_if.sink         req,
  drc_if.source       rsp
);
  localparam int unsigned Aw = $clog2(CACHE_ENTRIES);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StRank  = 3'd2;
  localparam logic [2:0] StApply = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [7:0] delay_q;
  logic [17:0] nonidem_q, statmask_q;
  drc_pkg::req_t req_q;
  drc_pkg::rsp_t rsp_q;

  logic [CACHE_ENTRIES-1:0] used_q, inprog_q, kstat_q, kbuf_q, stamp_ok_q;
  logic [31:0] xid_m [CACHE_ENTRIES];
  logic [4:0]  proc_m [CACHE_ENTRIES];
  logic [31:0] cli_m [CACHE_ENTRIES];
  logic [31:0] stamp_m [CACHE_ENTRIES];
  logic [31:0] status_m [CACHE_ENTRIES];
  logic [Aw-1:0] rank_m [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] rank_ok_q;

  logic [Aw:0] cnt_q;
  logic [Aw-1:0] idx;
  logic hit_q;
  logic [Aw-1:0] hit_idx_q, lru_idx_q, sel_q;
  logic [31:0] xid_r, cli_r, stamp_r, status_r;
  logic [4:0] proc_r;
  logic [Aw-1:0] rank_r;
  logic rd_v_q;
  logic [Aw-1:0] rd_idx_q;

  // Once a pass is done the read port holds the selected entry.
  assign idx = (cnt_q == (Aw+1)'(CACHE_ENTRIES)) ? sel_q : cnt_q[Aw-1:0];
  assign req.ready = (state_q == StIdle);
  assign rsp.valid = (state_q == StOut);
  assign rsp.data = rsp_q;

  // Registered memory reads, one address per cycle.
  always_ff @(posedge clk_i) begin
    xid_r <= xid_m[idx];
    proc_r <= proc_m[idx];
    cli_r <= cli_m[idx];
    stamp_r <= stamp_ok_q[idx] ? stamp_m[idx] : 32'd0;
    status_r <= status_m[idx];
    rank_r <= rank_ok_q[idx] ? rank_m[idx] : idx;
    rd_idx_q <= idx;
  end

  logic key_eq;
  assign key_eq = used_q[rd_idx_q] && xid_r == req_q.xid && proc_r == req_q.proc
                  && cli_r == req_q.client_addr;

  logic pb_ni, pb_st;
  assign pb_ni = (req_q.proc < 5'(drc_pkg::DefinedProcs)) && nonidem_q[req_q.proc];
  assign pb_st = (req_q.proc < 5'(drc_pkg::DefinedProcs)) && statmask_q[req_q.proc];

  logic drop_c;
  assign drop_c = inprog_q[sel_q] || ((req_q.now_seconds - stamp_r) < 32'(delay_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (req.valid) state_d = StScan;
      StScan:  if (rd_v_q && cnt_q == (Aw+1)'(CACHE_ENTRIES))
                 state_d = req_q.kind ? StApply : StRank;
      StRank:  if (rd_v_q && cnt_q == (Aw+1)'(CACHE_ENTRIES)) state_d = StApply;
      StApply: state_d = StOut;
      StOut:   if (rsp.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      delay_q <= 8'd2;
      nonidem_q <= 18'd65284;
      statmask_q <= 18'd48128;
      used_q <= '0;
      inprog_q <= '0;
      kstat_q <= '0;
      kbuf_q <= '0;
      stamp_ok_q <= '0;
      rank_ok_q <= '0;
      cnt_q <= '0;
      rd_v_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          drc_pkg::CfgDelay:   delay_q <= cfg_data_i[7:0];
          drc_pkg::CfgNonIdem: nonidem_q <= cfg_data_i;
          drc_pkg::CfgStatus:  statmask_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          cnt_q <= '0;
          rd_v_q <= 1'b0;
          hit_q <= 1'b0;
          if (req.valid) req_q <= req.data;
        end
        StScan: begin
          if (cnt_q != (Aw+1)'(CACHE_ENTRIES)) cnt_q <= cnt_q + 1'b1;
          else cnt_q <= '0;
          rd_v_q <= cnt_q != (Aw+1)'(CACHE_ENTRIES);
          if (rd_v_q) begin
            if (key_eq && !hit_q) begin
              hit_q <= 1'b1;
              hit_idx_q <= rd_idx_q;
            end
            if (rank_r == '0) lru_idx_q <= rd_idx_q;
          end
          if (state_d != StScan) begin
            sel_q <= hit_q ? hit_idx_q :
                     ((key_eq || rank_r == '0) ? rd_idx_q : lru_idx_q);
          end
        end
        StRank: begin
          if (cnt_q != (Aw+1)'(CACHE_ENTRIES)) cnt_q <= cnt_q + 1'b1;
          rd_v_q <= cnt_q != (Aw+1)'(CACHE_ENTRIES);
        end
        StApply: begin
          rsp_q.entry_index <= (req_q.kind && !hit_q) ? 6'd0 : 6'(sel_q);
          rsp_q.evicted_buffer <= !req_q.kind && !hit_q && used_q[sel_q] && kbuf_q[sel_q];
          rsp_q.cached_status <= (!req_q.kind && hit_q && !drop_c && kstat_q[sel_q]) ?
                                 status_r : 32'd0;
          if (req_q.kind) begin
            if (hit_q) begin
              rsp_q.action <= drc_pkg::ActUpdated;
              inprog_q[sel_q] <= 1'b0;
              stamp_ok_q[sel_q] <= 1'b1;
              if (req_q.reply_valid && pb_ni) begin
                if (pb_st) kstat_q[sel_q] <= 1'b1;
                else kbuf_q[sel_q] <= 1'b1;
              end
            end else begin
              rsp_q.action <= drc_pkg::ActNoMatch;
            end
          end else if (hit_q) begin
            if (drop_c)
              rsp_q.action <= drc_pkg::ActDrop;
            else if (kstat_q[sel_q]) rsp_q.action <= drc_pkg::ActReplyStatus;
            else if (kbuf_q[sel_q]) rsp_q.action <= drc_pkg::ActReplyBuffer;
            else begin
              rsp_q.action <= drc_pkg::ActDoIt;
              inprog_q[sel_q] <= 1'b1;
            end
          end else begin
            rsp_q.action <= drc_pkg::ActDoIt;
            used_q[sel_q] <= 1'b1;
            inprog_q[sel_q] <= 1'b1;
            kstat_q[sel_q] <= 1'b0;
            kbuf_q[sel_q] <= 1'b0;
          end
        end
        StOut: ;
        default: ;
      endcase
      if (state_q == StRank && rd_v_q) rank_ok_q[rd_idx_q] <= 1'b1;
    end
  end

  // Rank of the selected entry, captured during the scan.
  logic [Aw-1:0] srank_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StScan && rd_v_q) begin
      if (hit_q ? (rd_idx_q == hit_idx_q) : (key_eq || rank_r == '0))
        srank_q <= rank_r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StRank && rd_v_q) begin
      if (rd_idx_q == sel_q) rank_m[rd_idx_q] <= Aw'(CACHE_ENTRIES - 1);
      else if (rank_r > srank_q) rank_m[rd_idx_q] <= rank_r - 1'b1;
      else rank_m[rd_idx_q] <= rank_r;
    end
    if (state_q == StApply) begin
      if (req_q.kind) begin
        if (hit_q) begin
          stamp_m[sel_q] <= req_q.reply_valid ? req_q.now_seconds : 32'd0;
          if (req_q.reply_valid && pb_ni && pb_st) status_m[sel_q] <= req_q.reply_status;
        end
      end else if (hit_q) begin
        if (!drop_c && (kstat_q[sel_q] || kbuf_q[sel_q]))
          stamp_m[sel_q] <= req_q.now_seconds;
      end else begin
        xid_m[sel_q] <= req_q.xid;
        proc_m[sel_q] <= req_q.proc;
        cli_m[sel_q] <= req_q.client_addr;
      end
    end
  end

`ifndef SYNTHESIS
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !rsp.valid) else $error("result too early");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp_q))
    else $error("result changed while stalled");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.ready && rsp.valid)) else $error("accept during result");
`endif
endmodule

// File: test/tb_duplicate_request_cache.sv
`timescale 1ns / 1ps
// Testbench for duplicate_request_cache: random and directed request beats, an internal
// cache predictor, and field-by-field checking of response beats.
// Depends on drc_pkg, drc_if and the duplicate_request_cache RTL.
module tb_duplicate_request_cache;

  localparam int unsigned Entries = 64;
  localparam int unsigned WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = drc_pkg::CfgDelay;
  logic [17:0] cfg_data_i = '0;

  always #2 clk_i = ~clk_i;

  drc_if #(.payload_t(drc_pkg::req_t)) req_ch (.clk_i(clk_i));
  drc_if #(.payload_t(drc_pkg::rsp_t)) rsp_ch (.clk_i(clk_i));

  duplicate_request_cache #(.CACHE_ENTRIES(Entries)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  // Predictor state.
  logic [7:0] delay_q;
  logic [17:0] nonidem_q, status_q;
  logic used_q [Entries];
  logic busy_q [Entries];
  logic [31:0] xid_q [Entries];
  logic [4:0] proc_q [Entries];
  logic [31:0] client_q [Entries];
  logic [31:0] stamp_q [Entries];
  logic [31:0] status_word_q [Entries];
  logic [1:0] kept_q [Entries];
  int unsigned rank_q [Entries];

  drc_pkg::req_t pending_reqs[$];
  drc_pkg::rsp_t expected_rsps[$];
  int errors = 0;
  int watchdog = 0;
  logic req_fire = 1'b0;

  // Keys already issued, so lookups can repeat them and updates can match.
  logic [31:0] key_xid[$];
  logic [4:0] key_proc[$];
  logic [31:0] key_client[$];
  logic [31:0] now_clock = 32'd100;

  function automatic void reset_cache();
    delay_q = 8'd2;
    nonidem_q = 18'd65284;
    status_q = 18'd48128;
    for (int i = 0; i < Entries; i++) begin
      used_q[i] = 1'b0; busy_q[i] = 1'b0; stamp_q[i] = '0; kept_q[i] = '0;
      xid_q[i] = '0; proc_q[i] = '0; client_q[i] = '0; status_word_q[i] = '0;
      rank_q[i] = i;
    end
  endfunction

  function automatic void promote(int e);
    int unsigned r;
    r = rank_q[e];
    for (int i = 0; i < Entries; i++) if (rank_q[i] > r) rank_q[i]--;
    rank_q[e] = Entries - 1;
  endfunction

  function automatic logic proc_flag(logic [17:0] mask, logic [4:0] p);
    return (p < drc_pkg::DefinedProcs) ? mask[p] : 1'b0;
  endfunction

  function automatic drc_pkg::rsp_t predict_cache(drc_pkg::req_t r);
    drc_pkg::rsp_t o;
    int e;
    e = -1;
    o = '0;
    for (int i = 0; i < Entries; i++) begin
      if (e < 0 && used_q[i] && xid_q[i] == r.xid && proc_q[i] == r.proc &&
          client_q[i] == r.client_addr) e = i;
    end
    if (r.kind == 1'b0) begin
      if (e >= 0) begin
        promote(e);
        if (busy_q[e] || (r.now_seconds - stamp_q[e]) < {24'd0, delay_q}) begin
          o.action = drc_pkg::ActDrop;
        end else if (kept_q[e][0]) begin
          o.action = drc_pkg::ActReplyStatus;
          o.cached_status = status_word_q[e];
          stamp_q[e] = r.now_seconds;
        end else if (kept_q[e][1]) begin
          o.action = drc_pkg::ActReplyBuffer;
          stamp_q[e] = r.now_seconds;
        end else begin
          o.action = drc_pkg::ActDoIt;
          busy_q[e] = 1'b1;
        end
      end else begin
        e = 0;
        for (int i = Entries - 1; i >= 0; i--) if (rank_q[i] == 0) e = i;
        promote(e);
        o.evicted_buffer = used_q[e] && kept_q[e][1];
        used_q[e] = 1'b1; busy_q[e] = 1'b1; kept_q[e] = '0;
        xid_q[e] = r.xid; proc_q[e] = r.proc; client_q[e] = r.client_addr;
        o.action = drc_pkg::ActDoIt;
      end
      o.entry_index = e[5:0];
    end else if (e >= 0) begin
      busy_q[e] = 1'b0;
      if (r.reply_valid) begin
        stamp_q[e] = r.now_seconds;
        if (proc_flag(nonidem_q, r.proc)) begin
          if (proc_flag(status_q, r.proc)) begin
            status_word_q[e] = r.reply_status;
            kept_q[e][0] = 1'b1;
          end else begin
            kept_q[e][1] = 1'b1;
          end
        end
      end else begin
        stamp_q[e] = '0;
      end
      o.action = drc_pkg::ActUpdated;
      o.entry_index = e[5:0];
    end else begin
      o.action = drc_pkg::ActNoMatch;
    end
    return o;
  endfunction

  // Marks the beat taken at the last rising edge.
  always @(posedge clk_i) begin
    req_fire <= rst_ni && req_ch.valid && req_ch.ready;
  end

  // Driver: bursts of beats with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else if (!req_ch.valid || req_fire) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_ch.valid <= 1'b1;
        req_ch.data <= pending_reqs.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(12, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: phases of always-ready and random stalls.
  int stall_phase = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 300;
      if (stall_phase < 100) rsp_ch.ready <= 1'b1;
      else if (stall_phase < 200) rsp_ch.ready <= ($urandom_range(3, 0) != 0);
      else rsp_ch.ready <= ($urandom_range(4, 0) == 0);
    end
  end

  // Monitor: predict on accepted requests, check accepted responses.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        watchdog <= 0;
      else
        watchdog <= watchdog + 1;
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(predict_cache(req_ch.data));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t unexpected beat: expected none, actual %p", $time, rsp_ch.data);
          errors++;
        end else begin
          drc_pkg::rsp_t exp_rsp;
          exp_rsp = expected_rsps.pop_front();
          if (exp_rsp.action !== rsp_ch.data.action ||
              exp_rsp.cached_status !== rsp_ch.data.cached_status ||
              exp_rsp.entry_index !== rsp_ch.data.entry_index ||
              exp_rsp.evicted_buffer !== rsp_ch.data.evicted_buffer) begin
            $display("%0t mismatch: expected %p, actual %p", $time, exp_rsp, rsp_ch.data);
            errors++;
          end
        end
      end
      if (watchdog >= WatchdogLimit) begin
        $display("[duplicate_request_cache] ERROR");
        $finish;
      end
    end
  end

  function automatic drc_pkg::req_t make_req(logic kind, logic [31:0] x, logic [4:0] p,
                                             logic [31:0] c, logic [31:0] t, logic v,
                                             logic [31:0] s);
    drc_pkg::req_t r;
    r.kind = kind; r.xid = x; r.proc = p; r.client_addr = c;
    r.now_seconds = t; r.reply_valid = v; r.reply_status = s;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (2 * Entries + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [17:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      drc_pkg::CfgDelay: delay_q = value[7:0];
      drc_pkg::CfgNonIdem: nonidem_q = value;
      drc_pkg::CfgStatus: status_q = value;
      default: ;
    endcase
  endtask

  // Random request-response sequences over a small key pool.
  task automatic add_random(int count);
    int k;
    logic [31:0] x, c;
    logic [4:0] p;
    for (int n = 0; n < count; n++) begin
      now_clock = now_clock + $urandom_range(3, 0);
      if ($urandom_range(19, 0) == 0) now_clock = $urandom();
      if (key_xid.size() == 0 || $urandom_range(3, 0) == 0) begin
        x = $urandom(); c = $urandom(); p = 5'($urandom_range(31, 0));
        if ($urandom_range(1, 0) != 0) p = 5'($urandom_range(17, 0));
        key_xid.push_back(x); key_proc.push_back(p); key_client.push_back(c);
        if (key_xid.size() > 90) begin
          void'(key_xid.pop_front()); void'(key_proc.pop_front());
          void'(key_client.pop_front());
        end
      end else begin
        k = $urandom_range(key_xid.size() - 1, 0);
        x = key_xid[k]; p = key_proc[k]; c = key_client[k];
      end
      if ($urandom_range(9, 0) == 0) x = x ^ (32'd1 << $urandom_range(31, 0));
      pending_reqs.push_back(make_req(1'($urandom_range(1, 0)), x, p, c, now_clock,
                                      $urandom_range(4, 0) != 0, $urandom()));
    end
  endtask

  initial begin
    reset_cache();
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, each action, wrapped age, invalid reply, high procedures.
    pending_reqs.push_back(make_req(1'b1, 32'h0, 5'd0, 32'h0, 32'd5, 1'b1, 32'h0));
    pending_reqs.push_back(make_req(1'b0, 32'hFFFFFFFF, 5'd11, 32'hFFFFFFFF, 32'd10,
                                    1'b0, 32'h0));
    pending_reqs.push_back(make_req(1'b0, 32'hFFFFFFFF, 5'd11, 32'hFFFFFFFF, 32'd10,
                                    1'b0, 32'h0));
    pending_reqs.push_back(make_req(1'b1, 32'hFFFFFFFF, 5'd11, 32'hFFFFFFFF, 32'd20,
                                    1'b1, 32'hFFFFFFFF));
    pending_reqs.push_back(make_req(1'b0, 32'hFFFFFFFF, 5'd11, 32'hFFFFFFFF, 32'd21,
                                    1'b0, 32'h0));
    pending_reqs.push_back(make_req(1'b0, 32'hFFFFFFFF, 5'd11, 32'hFFFFFFFF, 32'd30,
                                    1'b0, 32'h0));
    pending_reqs.push_back(make_req(1'b0, 32'hFFFFFFFF, 5'd11, 32'hFFFFFFFF, 32'd5,
                                    1'b0, 32'h0));
    pending_reqs.push_back(make_req(1'b0, 32'h0, 5'd2, 32'h0, 32'd0, 1'b0, 32'h0));
    pending_reqs.push_back(make_req(1'b1, 32'h0, 5'd2, 32'h0, 32'd40, 1'b1, 32'h5A5A));
    pending_reqs.push_back(make_req(1'b0, 32'h0, 5'd2, 32'h0, 32'd50, 1'b0, 32'h0));
    pending_reqs.push_back(make_req(1'b1, 32'h0, 5'd2, 32'h0, 32'd60, 1'b0, 32'h0));
    pending_reqs.push_back(make_req(1'b0, 32'h0, 5'd2, 32'h0, 32'd61, 1'b0, 32'h0));
    pending_reqs.push_back(make_req(1'b0, 32'h1, 5'd31, 32'h2, 32'd70, 1'b0, 32'h0));
    pending_reqs.push_back(make_req(1'b1, 32'h1, 5'd31, 32'h2, 32'd70, 1'b1, 32'h1));
    pending_reqs.push_back(make_req(1'b0, 32'h1, 5'd31, 32'h2, 32'd90, 1'b0, 32'h0));
    pending_reqs.push_back(make_req(1'b0, 32'h1, 5'd31, 32'h2, 32'd90, 1'b0, 32'h0));
    // Lookups of eight new keys, each taking a free entry; the cache does not fill.
    for (int i = 0; i < 8; i++)
      pending_reqs.push_back(make_req(1'b0, 32'h100 + i, 5'd3, 32'h7, 32'd100,
                                      1'b0, 32'h0));
    wait_drained();

    add_random(300);
    wait_drained();
    write_reg(drc_pkg::CfgDelay, 18'd0);
    write_reg(drc_pkg::CfgNonIdem, 18'h3FFFF);
    write_reg(drc_pkg::CfgStatus, 18'h0);
    add_random(350);
    wait_drained();
    write_reg(drc_pkg::CfgDelay, 18'd255);
    write_reg(drc_pkg::CfgNonIdem, 18'h0);
    write_reg(drc_pkg::CfgStatus, 18'h3FFFF);
    add_random(250);
    wait_drained();
    write_reg(drc_pkg::CfgDelay, 18'd1);
    write_reg(drc_pkg::CfgNonIdem, 18'h3FFFF);
    write_reg(drc_pkg::CfgStatus, 18'h3FFFF);
    add_random(250);
    wait_drained();
    write_reg(drc_pkg::CfgDelay, 18'($urandom_range(255, 0)));
    write_reg(drc_pkg::CfgNonIdem, 18'($urandom()));
    write_reg(drc_pkg::CfgStatus, 18'($urandom()));
    add_random(280);
    wait_drained();

    if (errors == 0) begin
      $display("[duplicate_request_cache] OK");
    end else begin
      $display("[duplicate_request_cache] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/drc_pkg.sv
sv/drc_if.sv
sv/duplicate_request_cache.sv
test/tb_duplicate_request_cache.sv
